/* hw/rtl/bb3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared constants, types and helpers for the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

  // Default line length that the line store is sized for
  localparam int MAX_WIDTH_DEF = 1024;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

  localparam int IMG_W_W = 11;
  localparam int IMG_H_W = 16;
  localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 16'd768;

  // Output field widths
  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int ROW_W  = 16;
  localparam int OCOL_W = 10;

  // Result bundle queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

  // Divide by nine: floor(s * 7282 / 65536) is exact for s below 2304
  localparam int SUM_W  = 12;
  localparam int RCP_W  = 13;
  localparam int PROD_W = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP9 = 13'd7282;

  typedef logic [PIX_W-1:0] pixel_t;

  // All results caused by one input pixel
  typedef struct packed {
    logic [3:0]        mask;     // which of the four results exist
    logic [ROW_W-1:0]  row;      // row of the input pixel
    logic [OCOL_W-1:0] col_m1;   // column of the input pixel minus one
    pixel_t            pix_ctr;  // blurred or copied window center
    pixel_t            pix_up;   // pixel above the input, last column
    pixel_t            pix_left; // pixel left of the input, last row
    pixel_t            pix_in;   // input pixel itself
  } bundle_t;

  // Sum of three channel samples
  function automatic logic [SUM_W-1:0] sum3(input logic [CH_W-1:0] a,
                                            input logic [CH_W-1:0] b,
                                            input logic [CH_W-1:0] c);
    sum3 = SUM_W'(a) + SUM_W'(b) + SUM_W'(c);
  endfunction

  // Truncating divide by nine through the reciprocal
  function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(s) * PROD_W'(RECIP9);
    div9 = prod[23:16];
  endfunction

endpackage

/* hw/rtl/box_blur_3x3_rgb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// Streaming 3x3 box filter over RGB frames with border pass-through.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter in raster order on in_* (valid/stall). Each accepted pixel
//   at (r,c) causes zero to four results on out_*, each tagged with its row
//   and column; out_run_last marks the last result of that pixel. Interior
//   pixels are the truncated per-channel mean of the 3x3 neighborhood, the
//   border ring is copied through unchanged.
//   A result passes the line store, window, sum and divide stages, the result
//   queue and the output register. Throughput: one pixel per cycle while
//   in_stall is low, set by the single read-modify-write of the combined
//   line store per pixel; the rare extra results at row end and in the last
//   row are serialized on out_*. Up to eight pixels may be in flight; in_stall
//   rises when all eight slots are taken and falls as result bundles drain.
//   Writing image_width or image_height restarts the frame at (0,0); write
//   only while the block is idle.
//   Reset clears counters, the pipeline and the result queue and loads
//   width 1024 and height 768. The line store needs no clearing.
//   While out_stall is high the presented result holds; the pipeline keeps
//   running into the result queue; new pixels wait on in_stall instead.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data,
  // pixel input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_blue,
  input  logic [7:0]                     in_green,
  input  logic [7:0]                     in_red,
  // result output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_blue,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_red,
  output logic [15:0]                    out_row,
  output logic [9:0]                     out_column,
  output logic                           out_run_last
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WXW = (bb3_pkg::IMG_W_W > CW + 1) ? bb3_pkg::IMG_W_W : CW + 1;
  localparam int CH  = bb3_pkg::CH_W;

  // --------------------------------------------------------------------------
  // Configuration registers and effective frame size
  // --------------------------------------------------------------------------
  logic [bb3_pkg::IMG_W_W-1:0] width_r;
  logic [bb3_pkg::IMG_H_W-1:0] height_r;
  logic                        cfg_hit;
  logic [WXW-1:0]              width_x;
  logic [CW-1:0]               last_col;
  logic [bb3_pkg::ROW_W-1:0]   last_row;
  logic [bb3_pkg::OCOL_W-1:0]  last_col10;

  assign cfg_hit = cfg_wr_en && ((cfg_index == bb3_pkg::CFG_IDX_WIDTH) ||
                                 (cfg_index == bb3_pkg::CFG_IDX_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bb3_pkg::WIDTH_RESET;
      height_r <= bb3_pkg::HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == bb3_pkg::CFG_IDX_WIDTH) begin
        width_r <= cfg_data[bb3_pkg::IMG_W_W-1:0];
      end else if (cfg_index == bb3_pkg::CFG_IDX_HEIGHT) begin
        height_r <= cfg_data[bb3_pkg::IMG_H_W-1:0];
      end
    end
  end

  // Clamp width to 1..MAX_WIDTH and height to at least one row
  assign width_x = WXW'(width_r);

  always_comb begin
    priority if (width_x == '0) begin
      last_col = '0;
    end else if (width_x > WXW'(MAX_WIDTH)) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else begin
      last_col = CW'(width_x - WXW'(1));
    end
  end

  assign last_row   = (height_r == '0) ? '0 : height_r - 16'd1;
  assign last_col10 = bb3_pkg::OCOL_W'(last_col);

  // --------------------------------------------------------------------------
  // Input acceptance and raster counters
  // --------------------------------------------------------------------------
  logic                         in_acc;
  logic [bb3_pkg::OCC_W-1:0]    occ_r;
  logic [bb3_pkg::ROW_W-1:0]    row_r;
  logic [CW-1:0]                col_r;
  logic                         col_end;
  logic                         row_end;
  logic [3:0]                   in_mask;
  logic                         in_mean;
  bb3_pkg::pixel_t              in_pix;

  assign in_stall = (occ_r == bb3_pkg::OCC_W'(bb3_pkg::FIFO_DEPTH));
  assign in_acc   = in_valid && !in_stall;
  assign in_pix   = {in_red, in_green, in_blue};

  assign col_end = (col_r == last_col);
  assign row_end = (row_r == last_row);

  // Results: center, up at row end, left in last row, self at frame end
  assign in_mask[0] = (row_r != '0) && (col_r != '0);
  assign in_mask[1] = (row_r != '0) && col_end;
  assign in_mask[2] = row_end && (col_r != '0);
  assign in_mask[3] = row_end && col_end;
  assign in_mean    = (row_r >= 16'd2) && (col_r >= CW'(2));

  // Advance column and row, restart on a register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (cfg_hit) begin
      row_r <= '0;
      col_r <= '0;
    end else if (in_acc) begin
      if (col_end) begin
        col_r <= '0;
        row_r <= row_end ? '0 : row_r + 16'd1;
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: combined line store, {older, newer} per column
  // --------------------------------------------------------------------------
  logic [2*bb3_pkg::PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*bb3_pkg::PIX_W-1:0] rd_r;
  logic [2*bb3_pkg::PIX_W-1:0] fwd_data_r;
  logic [2*bb3_pkg::PIX_W-1:0] mem_out;
  logic                        fwd_r;
  logic                        s1_v_r;
  bb3_pkg::pixel_t             s1_pix_r;
  logic [bb3_pkg::ROW_W-1:0]   s1_row_r;
  logic [CW-1:0]               s1_col_r;
  logic [3:0]                  s1_mask_r;
  logic                        s1_mean_r;
  bb3_pkg::pixel_t             col_old;
  bb3_pkg::pixel_t             col_new;

  assign mem_out = fwd_r ? fwd_data_r : rd_r;
  assign col_old = mem_out[2*bb3_pkg::PIX_W-1:bb3_pkg::PIX_W];
  assign col_new = mem_out[bb3_pkg::PIX_W-1:0];

  // Read the column for the new pixel, write back the shifted pair
  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      line_mem[s1_col_r] <= {col_new, s1_pix_r};
    end
    if (in_acc) begin
      rd_r <= line_mem[col_r];
    end
  end

  // Forward the write-back when the next pixel reads the same column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= in_acc && s1_v_r && (s1_col_r == col_r);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= {col_new, s1_pix_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r  <= in_pix;
      s1_row_r  <= row_r;
      s1_col_r  <= col_r;
      s1_mask_r <= in_mask;
      s1_mean_r <= in_mean;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: 3x3 window, index col*3+row, oldest column first
  // --------------------------------------------------------------------------
  bb3_pkg::pixel_t           win_r [9];
  logic                      s2_v_r;
  logic [bb3_pkg::ROW_W-1:0] s2_row_r;
  logic [CW-1:0]             s2_col_r;
  logic [3:0]                s2_mask_r;
  logic                      s2_mean_r;

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= win_r[i+3];
      end
      win_r[6] <= col_old;
      win_r[7] <= col_new;
      win_r[8] <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_row_r  <= s1_row_r;
      s2_col_r  <= s1_col_r;
      s2_mask_r <= s1_mask_r;
      s2_mean_r <= s1_mean_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: channel sums and captured border pixels
  // --------------------------------------------------------------------------
  logic [bb3_pkg::SUM_W-1:0] sum_nxt [3];
  logic [bb3_pkg::SUM_W-1:0] s3_sum_r [3];
  logic                      s3_v_r;
  logic [bb3_pkg::ROW_W-1:0] s3_row_r;
  logic [CW-1:0]             s3_col_r;
  logic [3:0]                s3_mask_r;
  logic                      s3_mean_r;
  bb3_pkg::pixel_t           s3_ctr_r;
  bb3_pkg::pixel_t           s3_up_r;
  bb3_pkg::pixel_t           s3_left_r;
  bb3_pkg::pixel_t           s3_in_r;

  // Per channel: three column sums, then their total
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_nxt[ch] = bb3_pkg::sum3(win_r[0][ch*CH +: CH], win_r[1][ch*CH +: CH],
                                  win_r[2][ch*CH +: CH])
                  + bb3_pkg::sum3(win_r[3][ch*CH +: CH], win_r[4][ch*CH +: CH],
                                  win_r[5][ch*CH +: CH])
                  + bb3_pkg::sum3(win_r[6][ch*CH +: CH], win_r[7][ch*CH +: CH],
                                  win_r[8][ch*CH +: CH]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      s3_row_r  <= s2_row_r;
      s3_col_r  <= s2_col_r;
      s3_mask_r <= s2_mask_r;
      s3_mean_r <= s2_mean_r;
      s3_ctr_r  <= win_r[4];
      s3_up_r   <= win_r[7];
      s3_left_r <= win_r[5];
      s3_in_r   <= win_r[8];
      for (int ch = 0; ch < 3; ch++) begin
        s3_sum_r[ch] <= sum_nxt[ch];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: divide by nine, assemble the bundle, push into the queue
  // --------------------------------------------------------------------------
  bb3_pkg::bundle_t push_bundle;
  bb3_pkg::pixel_t  mean_pix;

  assign mean_pix = {bb3_pkg::div9(s3_sum_r[2]), bb3_pkg::div9(s3_sum_r[1]),
                     bb3_pkg::div9(s3_sum_r[0])};

  always_comb begin
    push_bundle.mask     = s3_mask_r;
    push_bundle.row      = s3_row_r;
    push_bundle.col_m1   = bb3_pkg::OCOL_W'(s3_col_r - CW'(1));
    push_bundle.pix_ctr  = s3_mean_r ? mean_pix : s3_ctr_r;
    push_bundle.pix_up   = s3_up_r;
    push_bundle.pix_left = s3_left_r;
    push_bundle.pix_in   = s3_in_r;
  end

  // --------------------------------------------------------------------------
  // Result bundle queue
  // --------------------------------------------------------------------------
  bb3_pkg::bundle_t                fifo_r [bb3_pkg::FIFO_DEPTH];
  logic [bb3_pkg::FIFO_PTR_W-1:0]  wr_ptr_r;
  logic [bb3_pkg::FIFO_PTR_W-1:0]  rd_ptr_r;
  logic [bb3_pkg::OCC_W-1:0]       fcnt_r;
  logic                            pop;
  bb3_pkg::bundle_t                head;

  assign head = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (s3_v_r) begin
      fifo_r[wr_ptr_r] <= push_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fcnt_r   <= '0;
    end else begin
      if (s3_v_r) begin
        wr_ptr_r <= wr_ptr_r + bb3_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + bb3_pkg::FIFO_PTR_W'(1);
      end
      fcnt_r <= fcnt_r + bb3_pkg::OCC_W'(s3_v_r) - bb3_pkg::OCC_W'(pop);
    end
  end

  // Track pixels in flight from acceptance until their bundle retires
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_r + bb3_pkg::OCC_W'(in_acc) - bb3_pkg::OCC_W'(pop);
    end
  end

  // --------------------------------------------------------------------------
  // Serializer: one result per cycle while out_stall is low, taken from the head bundle
  // --------------------------------------------------------------------------
  logic [3:0]                 done_r;
  logic [3:0]                 rem;
  logic [3:0]                 pick;
  logic                       out_free;
  logic                       emit;
  logic                       emit_last;
  bb3_pkg::pixel_t            sel_pix;
  logic [bb3_pkg::ROW_W-1:0]  sel_row;
  logic [bb3_pkg::OCOL_W-1:0] sel_col;
  logic                       out_valid_r;
  bb3_pkg::pixel_t            out_pix_r;
  logic [bb3_pkg::ROW_W-1:0]  out_row_r;
  logic [bb3_pkg::OCOL_W-1:0] out_col_r;
  logic                       out_last_r;

  assign rem      = head.mask & ~done_r;
  assign out_free = !out_valid_r || !out_stall;

  // Take the lowest pending result in emission order
  always_comb begin
    pick    = '0;
    sel_pix = head.pix_in;
    sel_row = head.row;
    sel_col = last_col10;
    priority if (rem[0]) begin
      pick    = 4'b0001;
      sel_pix = head.pix_ctr;
      sel_row = head.row - 16'd1;
      sel_col = head.col_m1;
    end else if (rem[1]) begin
      pick    = 4'b0010;
      sel_pix = head.pix_up;
      sel_row = head.row - 16'd1;
      sel_col = last_col10;
    end else if (rem[2]) begin
      pick    = 4'b0100;
      sel_pix = head.pix_left;
      sel_row = head.row;
      sel_col = head.col_m1;
    end else if (rem[3]) begin
      pick    = 4'b1000;
      sel_pix = head.pix_in;
      sel_row = head.row;
      sel_col = last_col10;
    end else begin
      pick    = '0;
    end
  end

  assign emit      = (fcnt_r != '0) && (rem != '0) && out_free;
  assign emit_last = ((rem & ~pick) == '0);
  assign pop       = (fcnt_r != '0) && ((rem == '0) || (emit && emit_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
    end else if (pop) begin
      done_r <= '0;
    end else if (emit) begin
      done_r <= done_r | pick;
    end
  end

  // Output register: load when empty or being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pix_r  <= sel_pix;
      out_row_r  <= sel_row;
      out_col_r  <= sel_col;
      out_last_r <= emit_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_blue     = out_pix_r[7:0];
  assign out_green    = out_pix_r[15:8];
  assign out_red      = out_pix_r[23:16];
  assign out_row      = out_row_r;
  assign out_column   = out_col_r;
  assign out_run_last = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= bb3_pkg::OCC_W'(bb3_pkg::FIFO_DEPTH))
    else $error("pixels in flight exceed queue depth");

  a_fifo_le_occ: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= occ_r)
    else $error("queued bundles exceed pixels in flight");

  a_done_subset: assert property (@(posedge clk) disable iff (!rst_n)
    (fcnt_r != '0) |-> ((done_r & ~head.mask) == '0))
    else $error("emitted result not present in head bundle");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (fcnt_r == '0) |-> (done_r == '0))
    else $error("serializer progress left over with empty queue");

endmodule
